/* design/sound_voice_allocator_core_assert.svh */
// Assertion macros used by the checker file.
`ifndef SOUND_VOICE_ALLOCATOR_CORE_ASSERT_SVH
`define SOUND_VOICE_ALLOCATOR_CORE_ASSERT_SVH

// Concurrent assertion, masked while reset is high.
`define SVA_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sound voice allocator assertion failed");

// Concurrent assertion that also holds across reset.
`define SVA_ASSERT(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("sound voice allocator assertion failed");

`endif

/* design/sva_pkg.sv */
package sva_pkg;

   localparam int CHANNELS    = 4;
   localparam int CHAN_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int SOUND_W     = 8;
   localparam int SOURCE_W    = 16;
   localparam int POS_W       = 32;
   localparam int PRIO_W      = 8;
   localparam int LEN_W       = 24;
   localparam int QUAD_W      = 32;
   localparam int EFFVOL_W    = 8;
   localparam int OUTCOME_W   = 2;
   localparam int CHAN_FIELD_W = 4;
   localparam int VOL_W       = 15;

   // adder wide enough for exact differences and sums of 32-bit positions
   localparam int ALU_W       = POS_W + 2;
   localparam int QUARTER_W   = LEN_W - 2;
   localparam int ATTEN_W     = 7;
   localparam int DIST_SHIFT  = 20;
   localparam logic [ATTEN_W-1:0]  ATTEN_FULL    = 7'd127;
   localparam logic [EFFVOL_W-1:0] EFFVOL_RESET  = 8'd128;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_STARTED   = 2'd0,
      OUT_TOO_FAR   = 2'd1,
      OUT_DUPLICATE = 2'd2,
      OUT_NO_FREE   = 2'd3
   } outcome_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DX_SUB,
      ST_DX_ABS,
      ST_DY_SUB,
      ST_DY_ABS,
      ST_CMP,
      ST_SUM,
      ST_DIST,
      ST_SCAN,
      ST_STEAL,
      ST_STOP,
      ST_RESP
   } state_type;

endpackage

/* design/sva_intf.sv */
interface sva_req_if;
   import sva_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [SOUND_W-1:0]         effect_id;
   logic [SOURCE_W-1:0]        source_id;
   logic                       at_listener;
   logic signed [POS_W-1:0]    source_x;
   logic signed [POS_W-1:0]    source_y;
   logic signed [POS_W-1:0]    listener_x;
   logic signed [POS_W-1:0]    listener_y;
   logic [PRIO_W-1:0]          sound_priority;
   logic                       singular;
   logic [LEN_W-1:0]           length_samples;
   logic signed [QUAD_W-1:0]   now_quad;

   modport source (
      output valid, effect_id, source_id, at_listener, source_x, source_y,
             listener_x, listener_y, sound_priority, singular, length_samples,
             now_quad,
      input  ready
   );

   modport sink (
      input  valid, effect_id, source_id, at_listener, source_x, source_y,
             listener_x, listener_y, sound_priority, singular, length_samples,
             now_quad,
      output ready
   );
endinterface

interface sva_rsp_if;
   import sva_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OUTCOME_W-1:0]       outcome;
   logic [CHAN_FIELD_W-1:0]    channel_index;
   logic [VOL_W-1:0]           channel_volume;
   logic signed [QUAD_W-1:0]   stop_time;

   modport source (
      output valid, outcome, channel_index, channel_volume, stop_time,
      input  ready
   );

   modport sink (
      input  valid, outcome, channel_index, channel_volume, stop_time,
      output ready
   );
endinterface

interface sva_csr_if;
   import sva_pkg::*;

   logic                valid;
   logic                ready;
   logic [EFFVOL_W-1:0] effects_volume;

   modport source (output valid, effects_volume, input ready);
   modport sink   (input valid, effects_volume, output ready);
endinterface

/* design/sound_voice_allocator_core.sv */
// Sound voice allocator. Each request transfer on req_ch asks to start a sound
// effect and produces exactly one result transfer on rsp_ch. Unless the request
// is at the listener, an attenuation is derived from the octagonal distance
// estimate dx + dy - min(dx,dy)/2; sources whose distance >> 20 exceeds 127
// come back as too far. Otherwise the channels are scanned one per cycle: a
// same-quad duplicate is rejected, a singular or same-source match is taken,
// else the last dead (or empty) channel, else a second pass steals the first
// busy channel whose priority value is not lower than the request's, else the
// request is rejected as no channel free. A started channel gets volume
// attenuation * effects_volume and stop time now_quad + length_samples/4.
// Timing: the block takes one request at a time. Everything runs through one
// 34-bit adder under a small sequencer: the distance states (skipped at the
// listener), the match scan, the steal pass if needed, and a stop state for
// the stop time and the channel write; then the result is offered and held
// until rsp_ch takes it, and req_ch is ready again the cycle after the result
// transfer.
// csr_ch is always ready; write it only while idle.
module sound_voice_allocator_core (
   input logic        clock,
   input logic        reset,
   sva_req_if.sink    req_ch,
   sva_rsp_if.source  rsp_ch,
   sva_csr_if.sink    csr_ch
);
   import sva_pkg::*;

   // sequencer
   state_type state_ff, state_in;

   // captured request
   logic [SOUND_W-1:0]   snd_ff, snd_in;
   logic [SOURCE_W-1:0]  src_ff, src_in;
   logic [POS_W-1:0]     sx_ff, sx_in, sy_ff, sy_in, lx_ff, lx_in, ly_ff, ly_in;
   logic [PRIO_W-1:0]    prio_ff, prio_in;
   logic                 sing_ff, sing_in;
   logic [QUARTER_W-1:0] quarter_ff, quarter_in;
   logic [QUAD_W-1:0]    now_ff, now_in;

   // distance working registers
   logic [ALU_W-1:0]     dx_ff, dx_in, dy_ff, dy_in;
   logic [POS_W-1:0]     half_ff, half_in;
   logic [ATTEN_W-1:0]   atten_ff, atten_in;

   // scan state
   logic [CHAN_IDX_W-1:0] idx_ff, idx_in, pick_ff, pick_in;
   logic                  have_pick_ff, have_pick_in;

   // result register
   outcome_type          outcome_ff, outcome_in;
   logic [VOL_W-1:0]     vol_ff, vol_in;
   logic [QUAD_W-1:0]    stop_ff, stop_in;

   // configuration
   logic [EFFVOL_W-1:0]  effvol_ff, effvol_in;

   // channel table
   logic                 used_ff    [CHANNELS];
   logic [SOUND_W-1:0]   sound_ff   [CHANNELS];
   logic [SOURCE_W-1:0]  source_ff  [CHANNELS];
   logic [PRIO_W-1:0]    ch_prio_ff [CHANNELS];
   logic [QUAD_W-1:0]    start_ff   [CHANNELS];
   logic [QUAD_W-1:0]    ch_stop_ff [CHANNELS];
   logic                 chan_we;

   // shared adder
   logic [ALU_W-1:0]     alu_a, alu_b, alu_res;
   logic                 alu_cin;

   // per-channel tests at idx_ff
   logic req_xfer;
   logic last_ch, match_snd, is_dup, is_take, is_dead, can_steal;
   logic too_far;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign alu_res  = alu_a + alu_b + ALU_W'(alu_cin);

   assign last_ch   = (idx_ff == CHAN_IDX_W'(CHANNELS - 1));
   assign match_snd = used_ff[idx_ff] && (sound_ff[idx_ff] == snd_ff);
   assign is_dup    = match_snd && (start_ff[idx_ff] == now_ff);
   // empty channels still compare on source, source 0 included
   assign is_take   = (match_snd && sing_ff) || (source_ff[idx_ff] == src_ff);
   assign is_dead   = !used_ff[idx_ff] ||
                      ($signed(ch_stop_ff[idx_ff]) <= $signed(now_ff));
   assign can_steal = used_ff[idx_ff] && (ch_prio_ff[idx_ff] >= prio_ff);

   // distance is in alu_res during ST_DIST
   assign too_far = |alu_res[ALU_W-1:DIST_SHIFT+ATTEN_W];

   // adder operand select
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_cin = 1'b0;
      case (state_ff)
         ST_DX_SUB: begin
            alu_a   = ALU_W'($signed(sx_ff));
            alu_b   = ~ALU_W'($signed(lx_ff));
            alu_cin = 1'b1;
         end
         ST_DX_ABS: begin
            alu_b   = dx_ff[ALU_W-1] ? ~dx_ff : dx_ff;
            alu_cin = dx_ff[ALU_W-1];
         end
         ST_DY_SUB: begin
            alu_a   = ALU_W'($signed(sy_ff));
            alu_b   = ~ALU_W'($signed(ly_ff));
            alu_cin = 1'b1;
         end
         ST_DY_ABS: begin
            alu_b   = dy_ff[ALU_W-1] ? ~dy_ff : dy_ff;
            alu_cin = dy_ff[ALU_W-1];
         end
         ST_CMP: begin
            alu_a   = dx_ff;
            alu_b   = ~dy_ff;
            alu_cin = 1'b1;
         end
         ST_SUM: begin
            alu_a = dx_ff;
            alu_b = dy_ff;
         end
         ST_DIST: begin
            alu_a   = dx_ff;
            alu_b   = ~ALU_W'(half_ff);
            alu_cin = 1'b1;
         end
         ST_STOP: begin
            alu_a = ALU_W'(now_ff);
            alu_b = ALU_W'(quarter_ff);
         end
         default: begin
            alu_a   = '0;
            alu_b   = '0;
            alu_cin = 1'b0;
         end
      endcase
   end

   // sequencer: next state and datapath loads
   always_comb begin
      state_in     = state_ff;
      snd_in       = snd_ff;
      src_in       = src_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      lx_in        = lx_ff;
      ly_in        = ly_ff;
      prio_in      = prio_ff;
      sing_in      = sing_ff;
      quarter_in   = quarter_ff;
      now_in       = now_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      half_in      = half_ff;
      atten_in     = atten_ff;
      idx_in       = idx_ff;
      pick_in      = pick_ff;
      have_pick_in = have_pick_ff;
      outcome_in   = outcome_ff;
      vol_in       = vol_ff;
      stop_in      = stop_ff;
      chan_we      = 1'b0;
      effvol_in    = (csr_ch.valid && csr_ch.ready) ? csr_ch.effects_volume : effvol_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               snd_in       = req_ch.effect_id;
               src_in       = req_ch.source_id;
               sx_in        = req_ch.source_x;
               sy_in        = req_ch.source_y;
               lx_in        = req_ch.listener_x;
               ly_in        = req_ch.listener_y;
               prio_in      = req_ch.sound_priority;
               sing_in      = req_ch.singular;
               quarter_in   = req_ch.length_samples[LEN_W-1:2];
               now_in       = req_ch.now_quad;
               idx_in       = '0;
               have_pick_in = 1'b0;
               if (req_ch.at_listener) begin
                  atten_in = ATTEN_FULL;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DX_SUB;
               end
            end
         end
         ST_DX_SUB: begin
            dx_in    = alu_res;
            state_in = ST_DX_ABS;
         end
         ST_DX_ABS: begin
            dx_in    = alu_res;
            state_in = ST_DY_SUB;
         end
         ST_DY_SUB: begin
            dy_in    = alu_res;
            state_in = ST_DY_ABS;
         end
         ST_DY_ABS: begin
            dy_in    = alu_res;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // sign of dx - dy picks the smaller one
            half_in  = alu_res[ALU_W-1] ? dx_ff[POS_W:1] : dy_ff[POS_W:1];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            dx_in    = alu_res;
            state_in = ST_DIST;
         end
         ST_DIST: begin
            if (too_far) begin
               outcome_in = OUT_TOO_FAR;
               state_in   = ST_RESP;
            end else begin
               atten_in = ATTEN_FULL - alu_res[DIST_SHIFT+ATTEN_W-1:DIST_SHIFT];
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (is_dup) begin
               outcome_in = OUT_DUPLICATE;
               state_in   = ST_RESP;
            end else if (is_take) begin
               pick_in  = idx_ff;
               state_in = ST_STOP;
            end else begin
               // keep the last dead channel seen
               if (is_dead) begin
                  pick_in      = idx_ff;
                  have_pick_in = 1'b1;
               end
               if (last_ch) begin
                  idx_in = '0;
                  if (is_dead || have_pick_ff) begin
                     state_in = ST_STOP;
                  end else begin
                     state_in = ST_STEAL;
                  end
               end else begin
                  idx_in = idx_ff + CHAN_IDX_W'(1);
               end
            end
         end
         ST_STEAL: begin
            if (can_steal) begin
               pick_in  = idx_ff;
               state_in = ST_STOP;
            end else if (last_ch) begin
               outcome_in = OUT_NO_FREE;
               state_in   = ST_RESP;
            end else begin
               idx_in = idx_ff + CHAN_IDX_W'(1);
            end
         end
         ST_STOP: begin
            stop_in    = alu_res[QUAD_W-1:0];
            vol_in     = VOL_W'(atten_ff) * VOL_W'(effvol_ff);
            outcome_in = OUT_STARTED;
            chan_we    = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         effvol_ff <= EFFVOL_RESET;
      end else begin
         state_ff  <= state_in;
         effvol_ff <= effvol_in;
      end
   end

   always_ff @(posedge clock) begin
      snd_ff       <= snd_in;
      src_ff       <= src_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      lx_ff        <= lx_in;
      ly_ff        <= ly_in;
      prio_ff      <= prio_in;
      sing_ff      <= sing_in;
      quarter_ff   <= quarter_in;
      now_ff       <= now_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      half_ff      <= half_in;
      atten_ff     <= atten_in;
      idx_ff       <= idx_in;
      pick_ff      <= pick_in;
      have_pick_ff <= have_pick_in;
      outcome_ff   <= outcome_in;
      vol_ff       <= vol_in;
      stop_ff      <= stop_in;
   end

   // channel table: used and source reset (source matters on empty channels)
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            used_ff[i]   <= 1'b0;
            source_ff[i] <= '0;
         end
      end else if (chan_we) begin
         used_ff[pick_ff]   <= 1'b1;
         source_ff[pick_ff] <= src_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (chan_we) begin
         sound_ff[pick_ff]   <= snd_ff;
         ch_prio_ff[pick_ff] <= prio_ff;
         start_ff[pick_ff]   <= now_ff;
         ch_stop_ff[pick_ff] <= alu_res[QUAD_W-1:0];
      end
   end

   // ports
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid          = (state_ff == ST_RESP);
   assign rsp_ch.outcome        = outcome_ff;
   assign rsp_ch.channel_index  = (outcome_ff == OUT_STARTED) ? CHAN_FIELD_W'(pick_ff) : '0;
   assign rsp_ch.channel_volume = (outcome_ff == OUT_STARTED) ? vol_ff : '0;
   assign rsp_ch.stop_time      = (outcome_ff == OUT_STARTED) ? stop_ff : '0;

endmodule

/* design/sva_checker.sv */
`include "sound_voice_allocator_core_assert.svh"

module sva_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [sva_pkg::OUTCOME_W-1:0]     rsp_outcome,
   input logic [sva_pkg::CHAN_FIELD_W-1:0]  rsp_channel_index,
   input logic [sva_pkg::VOL_W-1:0]         rsp_channel_volume,
   input logic [sva_pkg::QUAD_W-1:0]        rsp_stop_time
);
   import sva_pkg::*;

   logic req_xfer;
   logic rsp_stall;
   logic rsp_rejected;
   logic rsp_fields_zero;
   logic [OUTCOME_W+CHAN_FIELD_W+VOL_W+QUAD_W-1:0] rsp_word;

   assign req_xfer        = req_valid && req_ready;
   assign rsp_stall       = rsp_valid && !rsp_ready;
   assign rsp_rejected    = rsp_valid && (rsp_outcome != OUT_STARTED);
   assign rsp_fields_zero = (rsp_channel_index == '0) && (rsp_channel_volume == '0) &&
                            (rsp_stop_time == '0);
   assign rsp_word        = {rsp_outcome, rsp_channel_index, rsp_channel_volume,
                             rsp_stop_time};

   // out of reset: idle, taking requests, no result pending
   `SVA_ASSERT(a_reset_idle, clock, reset |=> (req_ready && !rsp_valid))

   // one request at a time: busy right after a request transfer
   `SVA_ASSERT_RST(a_busy_after_req, clock, reset, req_xfer |=> !req_ready)

   // never takes a request while a result waits
   `SVA_ASSERT_RST(a_no_overlap, clock, reset, !(rsp_valid && req_ready))

   // rejected results carry zero index, volume and stop time
   `SVA_ASSERT_RST(a_reject_zero, clock, reset, rsp_rejected |-> rsp_fields_zero)

   // stalled result holds
   `SVA_ASSERT_RST(a_rsp_hold, clock, reset, rsp_stall |=> (rsp_valid && $stable(rsp_word)))

endmodule

bind sound_voice_allocator_core sva_checker u_sva_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_outcome        (rsp_ch.outcome),
   .rsp_channel_index  (rsp_ch.channel_index),
   .rsp_channel_volume (rsp_ch.channel_volume),
   .rsp_stop_time      (rsp_ch.stop_time)
);
